// ===== sv/npi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npi_pkg
// Shared types and codes for the Neville interpolation core.
// ----------------------------------------------------------------------------
package npi_pkg;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DUP = 2'd1,
    ST_OVF = 2'd2,
    ST_SAT = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
    logic               last_point;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] error_estimate;
    status_t            status;
  } result_t;

endpackage

// ===== sv/npi_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npi_fifo
// Two-entry queue; decouples producer and consumer of one beat each.
// ----------------------------------------------------------------------------
module npi_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        wp_r <= ~wp_r;
      end
      if (do_rd) begin
        rp_r <= ~rp_r;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== sv/npi_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npi_engine
// Back end: stores points, runs the Neville c/d tableau on the last beat.
// ----------------------------------------------------------------------------
module npi_engine import npi_pkg::*; #(
  parameter int MAX_POINTS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  item_t   in_item,
  input  logic    in_avail,
  output logic    in_take,
  output result_t res,
  output logic    res_push,
  input  logic    res_full
);

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int NW  = 33 + FRAC_BITS;
  localparam int DCW = $clog2(NW + 1);
  localparam logic [CW-1:0]  MAXC = CW'(MAX_POINTS);
  localparam logic [63:0]    RND  = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic [31:0]    SMAX = 32'h7fff_ffff;
  localparam logic [31:0]    SMIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_SCAN, S_SEED, S_STEP, S_PREP, S_DIV, S_QFIX,
    S_MULD, S_MULC, S_WRC, S_CORR, S_ACC, S_DONE
  } state_t;

  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [31:0] c_mem [MAX_POINTS];
  logic signed [31:0] d_mem [MAX_POINTS];

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, k_r, k_nxt, m_r, m_nxt, i_r, i_nxt;
  logic          ovf_r, ovf_nxt, sat_r, sat_nxt, dup_r, dup_nxt, selc_r, selc_nxt;
  logic          qneg_r, qneg_nxt;
  logic signed [31:0] qx_r, qx_nxt, val_r, val_nxt, err_r, err_nxt;
  logic signed [31:0] ho_r, ho_nxt, hp_r, hp_nxt, q_r, q_nxt;
  logic [33:0]   best_r, best_nxt, rem_r, rem_nxt;
  logic [AW-1:0] ns_r, ns_nxt, xa_r, xa_nxt, xb_r, xb_nxt, ca_r, ca_nxt, da_r, da_nxt;
  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [32:0]   dsr_r, dsr_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] xa_q, xb_q, c_q, d_q;

  logic          x_we, c_we, d_we;
  logic [AW-1:0] w_a;
  logic signed [31:0] c_wd, d_wd;

  // combinational helpers
  logic signed [63:0] shf;
  logic signed [31:0] scaled;
  logic               scale_sat;
  logic signed [32:0] hoe, hpe, w33, den, sum33, dist_s;
  logic [33:0]        dist_abs;
  logic signed [NW-1:0] num;
  logic [33:0]        rem_sh;
  logic               ge;
  logic signed [31:0] corr;
  logic [CW:0]        lhs;
  logic [CW-1:0]      nm;

  always_comb begin
    shf = (prod_r + (prod_r[63] ? $signed(RND) : 64'sd0)) >>> FRAC_BITS;
    scale_sat = (shf[63:31] != {33{shf[63]}});
    scaled = scale_sat ? (shf[63] ? SMIN : SMAX) : shf[31:0];
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[w_a] <= in_item.point_x;
    end
    if (c_we) begin
      c_mem[w_a] <= c_wd;
    end
    if (d_we) begin
      d_mem[w_a] <= d_wd;
    end
    xa_q <= x_mem[xa_r];
    xb_q <= x_mem[xb_r];
    c_q  <= c_mem[ca_r];
    d_q  <= d_mem[da_r];
  end

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;
    cnt_nxt = cnt_r;  n_nxt = n_r;  k_nxt = k_r;  m_nxt = m_r;  i_nxt = i_r;
    ovf_nxt = ovf_r;  sat_nxt = sat_r;  dup_nxt = dup_r;  selc_nxt = selc_r;
    qneg_nxt = qneg_r;  qx_nxt = qx_r;  val_nxt = val_r;  err_nxt = err_r;
    ho_nxt = ho_r;  hp_nxt = hp_r;  q_nxt = q_r;  best_nxt = best_r;
    rem_nxt = rem_r;  ns_nxt = ns_r;  xa_nxt = xa_r;  xb_nxt = xb_r;
    ca_nxt = ca_r;  da_nxt = da_r;  dvd_nxt = dvd_r;  dsr_nxt = dsr_r;
    dcnt_nxt = dcnt_r;  prod_nxt = prod_r;
    in_take = 1'b0;  res_push = 1'b0;
    x_we = 1'b0;  c_we = 1'b0;  d_we = 1'b0;
    w_a = i_r[AW-1:0];  c_wd = scaled;  d_wd = scaled;

    hoe = {xa_q[31], xa_q} - {qx_r[31], qx_r};
    hpe = {xb_q[31], xb_q} - {qx_r[31], qx_r};
    w33 = {c_q[31], c_q} - {d_q[31], d_q};
    den = {xa_q[31], xa_q} - {xb_q[31], xb_q};
    num = {w33, {FRAC_BITS{1'b0}}};
    dist_s = {qx_r[31], qx_r} - {xa_q[31], xa_q};
    dist_abs = dist_s[32] ? 34'(-dist_s) : 34'(dist_s);
    if (dist_s[32]) begin
      dist_abs = 34'd0 - {dist_s[32], dist_s};
    end else begin
      dist_abs = {1'b0, dist_s};
    end
    rem_sh = {rem_r[32:0], dvd_r[NW-1]};
    ge = (rem_sh >= {1'b0, dsr_r});
    corr = selc_r ? c_q : d_q;
    sum33 = {val_r[31], val_r} + {corr[31], corr};
    lhs = {1'b0, CW'(ns_r)} << 1;
    nm = n_r - m_r;

    case (state_r)
      S_IDLE: begin
        if (in_avail) begin
          in_take = 1'b1;
          w_a = cnt_r[AW-1:0];
          c_wd = in_item.point_y;
          d_wd = in_item.point_y;
          if (cnt_r < MAXC) begin
            x_we = 1'b1;  c_we = 1'b1;  d_we = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item.last_point) begin
            n_nxt = (cnt_r < MAXC) ? cnt_r + CW'(1) : cnt_r;
            qx_nxt = in_item.query_x;
            sat_nxt = 1'b0;  dup_nxt = 1'b0;
            k_nxt = '0;  xa_nxt = '0;  ns_nxt = '0;
            best_nxt = '1;
            ret_nxt = S_SCAN;  state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: state_nxt = ret_r;
      S_SCAN: begin
        if (dist_abs < best_r) begin
          best_nxt = dist_abs;
          ns_nxt = k_r[AW-1:0];
        end
        k_nxt = k_r + CW'(1);
        if (k_r + CW'(1) < n_r) begin
          xa_nxt = AW'(k_r + CW'(1));
          ret_nxt = S_SCAN;
        end else begin
          ca_nxt = (dist_abs < best_r) ? k_r[AW-1:0] : ns_r;
          ret_nxt = S_SEED;
        end
        state_nxt = S_FETCH;
      end
      S_SEED: begin
        val_nxt = c_q;  err_nxt = '0;
        m_nxt = CW'(1);  i_nxt = '0;
        state_nxt = (n_r == CW'(1)) ? S_DONE : S_STEP;
      end
      S_STEP: begin
        xa_nxt = AW'(i_r);
        xb_nxt = AW'(i_r + m_r);
        ca_nxt = AW'(i_r + CW'(1));
        da_nxt = AW'(i_r);
        ret_nxt = S_PREP;  state_nxt = S_FETCH;
      end
      S_PREP: begin
        if (hoe[32] != hoe[31]) begin
          sat_nxt = 1'b1;
          ho_nxt = hoe[32] ? SMIN : SMAX;
        end else begin
          ho_nxt = hoe[31:0];
        end
        if (hpe[32] != hpe[31]) begin
          sat_nxt = 1'b1;
          hp_nxt = hpe[32] ? SMIN : SMAX;
        end else begin
          hp_nxt = hpe[31:0];
        end
        if (den == 33'sd0) begin
          dup_nxt = 1'b1;  state_nxt = S_DONE;
        end else begin
          dvd_nxt = num[NW-1] ? NW'(-num) : NW'(num);
          dsr_nxt = den[32] ? 33'(-den) : 33'(den);
          qneg_nxt = w33[32] ^ den[32];
          rem_nxt = '0;
          dcnt_nxt = DCW'(NW);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? rem_sh - {1'b0, dsr_r} : rem_sh;
        dvd_nxt = {dvd_r[NW-2:0], ge};
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == DCW'(1)) begin
          state_nxt = S_QFIX;
        end
      end
      S_QFIX: begin
        if (!qneg_r) begin
          if (dvd_r[NW-1:31] != '0) begin
            sat_nxt = 1'b1;  q_nxt = SMAX;
          end else begin
            q_nxt = dvd_r[31:0];
          end
        end else begin
          if ((dvd_r[NW-1:32] != '0) || (dvd_r[31] && (dvd_r[30:0] != '0))) begin
            sat_nxt = 1'b1;  q_nxt = SMIN;
          end else begin
            q_nxt = 32'd0 - dvd_r[31:0];
          end
        end
        state_nxt = S_MULD;
      end
      S_MULD: begin
        prod_nxt = hp_r * q_r;
        state_nxt = S_MULC;
      end
      S_MULC: begin
        d_we = 1'b1;
        if (scale_sat) sat_nxt = 1'b1;
        prod_nxt = ho_r * q_r;
        state_nxt = S_WRC;
      end
      S_WRC: begin
        c_we = 1'b1;
        if (scale_sat) sat_nxt = 1'b1;
        i_nxt = i_r + CW'(1);
        state_nxt = (i_r + CW'(1) < nm) ? S_STEP : S_CORR;
      end
      S_CORR: begin
        if (lhs < {1'b0, nm}) begin
          ca_nxt = ns_r;  selc_nxt = 1'b1;
        end else begin
          ns_nxt = ns_r - AW'(1);
          da_nxt = ns_r - AW'(1);
          selc_nxt = 1'b0;
        end
        ret_nxt = S_ACC;  state_nxt = S_FETCH;
      end
      S_ACC: begin
        err_nxt = corr;
        if (sum33[32] != sum33[31]) begin
          sat_nxt = 1'b1;
          val_nxt = sum33[32] ? SMIN : SMAX;
        end else begin
          val_nxt = sum33[31:0];
        end
        m_nxt = m_r + CW'(1);
        i_nxt = '0;
        state_nxt = (m_r + CW'(1) < n_r) ? S_STEP : S_DONE;
      end
      S_DONE: begin
        if (!res_full) begin
          res_push = 1'b1;
          cnt_nxt = '0;  ovf_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res.value = dup_r ? 32'sd0 : val_r;
    res.error_estimate = dup_r ? 32'sd0 : err_r;
    if (dup_r) res.status = ST_DUP;
    else if (ovf_r) res.status = ST_OVF;
    else if (sat_r) res.status = ST_SAT;
    else res.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      sat_r   <= 1'b0;
      dup_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      sat_r   <= sat_nxt;
      dup_r   <= dup_nxt;
    end
    n_r <= n_nxt;  k_r <= k_nxt;  m_r <= m_nxt;  i_r <= i_nxt;
    selc_r <= selc_nxt;  qneg_r <= qneg_nxt;  qx_r <= qx_nxt;
    val_r <= val_nxt;  err_r <= err_nxt;  ho_r <= ho_nxt;  hp_r <= hp_nxt;
    q_r <= q_nxt;  best_r <= best_nxt;  rem_r <= rem_nxt;  ns_r <= ns_nxt;
    xa_r <= xa_nxt;  xb_r <= xb_nxt;  ca_r <= ca_nxt;  da_r <= da_nxt;
    dvd_r <= dvd_nxt;  dsr_r <= dsr_nxt;  dcnt_r <= dcnt_nxt;  prod_r <= prod_nxt;
  end

endmodule

// ===== sv/neville_polynomial_interpolation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neville_polynomial_interpolation_core
// Neville polynomial interpolation in signed fixed point, queue-style ports.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake     | beat
//  --------+-----------+---------------+------------------------------------
//  in_*    | input     | push / full   | point_x, point_y, query_x, last_point
//  out_*   | output    | pop / empty   | value, error_estimate, status
//
// A point beat with last_point low is written to the point store. A last beat
// runs the tableau: a nearest-node scan, then for each of the n(n-1)/2 tableau
// entries a bit-serial divide (33+FRAC_BITS steps) and two multiplies, plus a
// correction step per order that adds the chosen c or d term to the value.
// Reset (rst_n low, synchronous) empties both queues and the point store.
// Input and output each sit behind a two-beat queue, so a stalled pop holds
// the engine only once its result cannot be queued.
// ----------------------------------------------------------------------------
module neville_polynomial_interpolation_core import npi_pkg::*; #(
  parameter int MAX_POINTS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_query_x,
  input  logic               in_last_point,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_error_estimate,
  output logic [1:0]         out_status
);

  item_t   in_beat, q_item;
  result_t eng_res, out_res;
  logic    q_empty, eng_take, eng_push, res_full;

  assign in_beat.point_x    = in_point_x;
  assign in_beat.point_y    = in_point_y;
  assign in_beat.query_x    = in_query_x;
  assign in_beat.last_point = in_last_point;

  // front queue: lets the host keep pushing points while the engine works
  npi_fifo #(.W($bits(item_t))) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (in_beat),
    .full    (full),
    .rd_en   (eng_take),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  npi_engine #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_eng (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (q_item),
    .in_avail (!q_empty),
    .in_take  (eng_take),
    .res      (eng_res),
    .res_push (eng_push),
    .res_full (res_full)
  );

  // result queue: finished beats wait here for pop
  npi_fifo #(.W($bits(result_t))) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (eng_push),
    .wr_data (eng_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign out_value          = out_res.value;
  assign out_error_estimate = out_res.error_estimate;
  assign out_status         = out_res.status;

endmodule

// ===== sv/npi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npi_checker
// Port-level checks for the interpolation core, bound to the top level.
// ----------------------------------------------------------------------------
module npi_checker import npi_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [31:0] out_value,
  input logic [31:0] out_error_estimate,
  input logic [1:0]  out_status
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_rst_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input queue full after reset");

  a_dup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_DUP) |-> (out_value == 32'd0 && out_error_estimate == 32'd0))
    else $error("duplicate-node beat carries nonzero data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

endmodule

bind neville_polynomial_interpolation_core npi_checker u_npi_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .full               (full),
  .pop                (pop),
  .empty              (empty),
  .out_value          (out_value),
  .out_error_estimate (out_error_estimate),
  .out_status         (out_status)
);
